### rtl/c8i_pkg.sv
`timescale 1ns / 1ps

package c8i_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int SIDX_W = $clog2(STACK_DEPTH);
	localparam int SLVL_W = $clog2(STACK_DEPTH + 1);

	localparam logic [11:0] PC_RESET = 12'h200;
	localparam logic [11:0] FONT_BASE = 12'h050;
	localparam int FONT_LEN = 80;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_STEP = 2'd1;
	localparam logic [1:0] KIND_ROW = 2'd2;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_OVER = 2'd1;
	localparam logic [1:0] STAT_UNDER = 2'd2;

	localparam logic [7:0] FONT [FONT_LEN] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	// Reset contents of main memory: font glyphs in their window, zero elsewhere
	function automatic logic [7:0] reset_byte(input logic [11:0] addr);
		logic [11:0] off;
		off = addr - FONT_BASE;
		if (addr >= FONT_BASE && off < 12'(FONT_LEN))
			return FONT[off[6:0]];
		return 8'h00;
	endfunction

	// Hundreds, tens and ones of an 8-bit value, one nibble each
	function automatic logic [11:0] bcd3(input logic [7:0] v);
		logic [3:0] h;
		logic [3:0] t;
		logic [7:0] r;
		h = 4'd0;
		t = 4'd0;
		r = v;
		if (r >= 8'd200) begin
			h = 4'd2;
			r = r - 8'd200;
		end else if (r >= 8'd100) begin
			h = 4'd1;
			r = r - 8'd100;
		end
		for (int k = 3; k >= 0; k--) begin
			if (r >= 8'(10 << k)) begin
				r = r - 8'(10 << k);
				t = t | 4'(1 << k);
			end
		end
		return {h, t, r[3:0]};
	endfunction

endpackage

### rtl/chip8_interpreter_core_top.sv
`timescale 1ns / 1ps

// CHIP-8 interpreter core.
// One command channel: an item is taken when start is high and busy is low.
// kind selects load (write load_byte at load_address), step (fetch and
// execute one instruction, then tick the timers) or row read (row_select).
// Every item gives exactly one result, shown for one cycle with done high;
// the receiver cannot stall and must take it in that cycle.
// Load, row read and unused kind go straight to the result. A step adds
// a flag write, a screen clear, a pass per sprite row, the three FX33
// digits or the FX55/FX65 copies as its instruction needs. The next item
// may start in the cycle done is high. Program memory, V registers, return
// stack and frame store are synchronous memories with one write port and
// one registered read port, so every step walks fetch, operand reads and
// write-back through these ports one access per cycle.
// After reset a clearing pass over every address loads the font, zeroes the
// rest of memory, the V registers and the frame; busy stays high meanwhile.
module chip8_interpreter_core_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  kind,
	input  logic [11:0] load_address,
	input  logic [7:0]  load_byte,
	input  logic [7:0]  random_byte,
	input  logic [4:0]  row_select,
	output logic        busy,
	output logic        done,
	output logic [11:0] program_counter,
	output logic [15:0] instruction,
	output logic [63:0] row_pixels,
	output logic        sound_on,
	output logic [1:0]  status
);
	import c8i_pkg::*;

	localparam logic [4:0] S_CLR = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_F1 = 5'd2;
	localparam logic [4:0] S_F2 = 5'd3;
	localparam logic [4:0] S_R1 = 5'd4;
	localparam logic [4:0] S_R2 = 5'd5;
	localparam logic [4:0] S_R3 = 5'd6;
	localparam logic [4:0] S_EX = 5'd7;
	localparam logic [4:0] S_WF = 5'd8;
	localparam logic [4:0] S_CLF = 5'd9;
	localparam logic [4:0] S_DR1 = 5'd10;
	localparam logic [4:0] S_DR2 = 5'd11;
	localparam logic [4:0] S_ST1 = 5'd12;
	localparam logic [4:0] S_ST2 = 5'd13;
	localparam logic [4:0] S_LD1 = 5'd14;
	localparam logic [4:0] S_LD2 = 5'd15;
	localparam logic [4:0] S_BCD = 5'd16;
	localparam logic [4:0] S_FIN = 5'd17;

	logic [4:0]  state_q;
	logic [11:0] cnt_q;
	logic [11:0] pc_q;
	logic [15:0] i_q;
	logic [SLVL_W-1:0] sl_q;
	logic [7:0]  dt_q;
	logic [7:0]  st_q;
	logic [1:0]  kind_q;
	logic [7:0]  rnd_q;
	logic [7:0]  hi_q;
	logic [15:0] op_q;
	logic [7:0]  vx_q;
	logic [7:0]  vy_q;
	logic [7:0]  v0_q;
	logic [3:0]  idx_q;
	logic        flag_q;
	logic [11:0] bcd_q;
	logic [1:0]  status_q;
	logic        done_q;
	logic [11:0] pc_out_q;
	logic [15:0] instr_q;
	logic [63:0] row_q;
	logic        sound_q;

	// memories
	logic [7:0]  mem [4096];
	logic [7:0]  mem_rdata_q;
	logic        mem_we;
	logic [11:0] mem_waddr;
	logic [7:0]  mem_wdata;
	logic [11:0] mem_raddr;

	logic [7:0]  vreg [16];
	logic [7:0]  v_rdata_q;
	logic        v_we;
	logic [3:0]  v_waddr;
	logic [7:0]  v_wdata;
	logic [3:0]  v_raddr;

	logic [63:0] fb [32];
	logic [63:0] fb_rdata_q;
	logic        fb_we;
	logic [4:0]  fb_waddr;
	logic [63:0] fb_wdata;
	logic [4:0]  fb_raddr;

	logic [11:0] stk [STACK_DEPTH];
	logic [11:0] stk_rdata_q;
	logic        stk_we;
	logic [SLVL_W-1:0] sl_m1;

	logic [3:0]  op_x;
	logic [3:0]  op_n;
	logic [7:0]  op_nn;
	logic [11:0] op_nnn;
	logic [11:0] pc_nxt;
	logic [11:0] pc_skip;
	logic [11:0] ia;
	logic [4:0]  drow;
	logic [63:0] spr_wide;
	logic [127:0] spr_dbl;
	logic [63:0] mask;
	logic [7:0]  alu_res;
	logic        alu_flag;
	logic        alu_wr;
	logic        alu_fop;
	logic [8:0]  add9;
	logic [7:0]  st_dec;
	logic [7:0]  dt_dec;
	logic [3:0]  bcd_dig;

	assign op_x = op_q[11:8];
	assign op_n = op_q[3:0];
	assign op_nn = op_q[7:0];
	assign op_nnn = op_q[11:0];
	assign pc_nxt = pc_q + 12'd2;
	assign pc_skip = pc_q + 12'd4;
	assign ia = i_q[11:0] + {8'd0, idx_q};
	assign drow = vy_q[4:0] + {1'b0, idx_q};
	assign sl_m1 = sl_q - SLVL_W'(1);
	assign spr_wide = {mem_rdata_q, 56'd0};
	assign spr_dbl = {spr_wide, spr_wide} >> vx_q[5:0];
	assign mask = spr_dbl[63:0];
	assign add9 = {1'b0, vx_q} + {1'b0, vy_q};
	assign st_dec = (st_q != 8'd0) ? st_q - 8'd1 : 8'd0;
	assign dt_dec = (dt_q != 8'd0) ? dt_q - 8'd1 : 8'd0;

	always_comb begin
		case (idx_q[1:0])
			2'd0: bcd_dig = bcd_q[11:8];
			2'd1: bcd_dig = bcd_q[7:4];
			default: bcd_dig = bcd_q[3:0];
		endcase
	end

	// 8XYn arithmetic
	always_comb begin
		alu_res = vx_q;
		alu_flag = 1'b0;
		alu_wr = 1'b1;
		alu_fop = 1'b0;
		unique case (op_n)
			4'h0: alu_res = vy_q;
			4'h1: alu_res = vx_q | vy_q;
			4'h2: alu_res = vx_q & vy_q;
			4'h3: alu_res = vx_q ^ vy_q;
			4'h4: begin
				alu_res = add9[7:0];
				alu_flag = add9[8];
				alu_fop = 1'b1;
			end
			4'h5: begin
				alu_res = vx_q - vy_q;
				alu_flag = vx_q >= vy_q;
				alu_fop = 1'b1;
			end
			4'h6: begin
				alu_res = {1'b0, vx_q[7:1]};
				alu_flag = vx_q[0];
				alu_fop = 1'b1;
			end
			4'h7: begin
				alu_res = vy_q - vx_q;
				alu_flag = vy_q >= vx_q;
				alu_fop = 1'b1;
			end
			4'hE: begin
				alu_res = {vx_q[6:0], 1'b0};
				alu_flag = vx_q[7];
				alu_fop = 1'b1;
			end
			default: alu_wr = 1'b0;
		endcase
	end

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = ia;
		mem_wdata = 8'd0;
		mem_raddr = pc_q;
		v_we = 1'b0;
		v_waddr = op_x;
		v_wdata = 8'd0;
		v_raddr = 4'd0;
		fb_we = 1'b0;
		fb_waddr = drow;
		fb_wdata = 64'd0;
		fb_raddr = drow;
		stk_we = 1'b0;
		unique case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
				mem_waddr = cnt_q;
				mem_wdata = reset_byte(cnt_q);
				v_we = cnt_q < 12'd16;
				v_waddr = cnt_q[3:0];
				fb_we = cnt_q < 12'd32;
				fb_waddr = cnt_q[4:0];
			end
			S_IDLE: begin
				fb_raddr = row_select;
				if (start && kind == KIND_LOAD) begin
					mem_we = 1'b1;
					mem_waddr = load_address;
					mem_wdata = load_byte;
				end
			end
			S_F1: mem_raddr = pc_q + 12'd1;
			S_F2: v_raddr = hi_q[3:0];
			S_R1: v_raddr = op_q[7:4];
			S_R2: v_raddr = 4'd0;
			S_EX: begin
				case (op_q[15:12])
					4'h2: stk_we = sl_q < SLVL_W'(STACK_DEPTH);
					4'h6: begin
						v_we = 1'b1;
						v_wdata = op_nn;
					end
					4'h7: begin
						v_we = 1'b1;
						v_wdata = vx_q + op_nn;
					end
					4'h8: begin
						v_we = alu_wr;
						v_wdata = alu_res;
					end
					4'hC: begin
						v_we = 1'b1;
						v_wdata = rnd_q & op_nn;
					end
					4'hF: begin
						v_we = op_nn == 8'h07;
						v_wdata = dt_q;
					end
					default: ;
				endcase
			end
			S_WF: begin
				v_we = 1'b1;
				v_waddr = 4'hF;
				v_wdata = {7'd0, flag_q};
			end
			S_CLF: begin
				fb_we = 1'b1;
				fb_waddr = cnt_q[4:0];
			end
			S_DR1: mem_raddr = ia;
			S_DR2: begin
				fb_we = 1'b1;
				fb_wdata = fb_rdata_q ^ mask;
			end
			S_ST1: v_raddr = idx_q;
			S_ST2: begin
				mem_we = 1'b1;
				mem_wdata = v_rdata_q;
			end
			S_LD1: mem_raddr = ia;
			S_LD2: begin
				v_we = 1'b1;
				v_waddr = idx_q;
				v_wdata = mem_rdata_q;
			end
			S_BCD: begin
				mem_we = 1'b1;
				mem_wdata = {4'd0, bcd_dig};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		mem_rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (v_we)
			vreg[v_waddr] <= v_wdata;
		v_rdata_q <= vreg[v_raddr];
	end

	always_ff @(posedge clk) begin
		if (fb_we)
			fb[fb_waddr] <= fb_wdata;
		fb_rdata_q <= fb[fb_raddr];
	end

	always_ff @(posedge clk) begin
		if (stk_we)
			stk[sl_q[SIDX_W-1:0]] <= pc_nxt;
		stk_rdata_q <= stk[sl_m1[SIDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cnt_q <= 12'd0;
			pc_q <= PC_RESET;
			i_q <= 16'd0;
			sl_q <= '0;
			dt_q <= 8'd0;
			st_q <= 8'd0;
			done_q <= 1'b0;
			status_q <= STAT_OK;
			kind_q <= KIND_LOAD;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					cnt_q <= cnt_q + 12'd1;
					if (cnt_q == 12'hFFF)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						kind_q <= kind;
						rnd_q <= random_byte;
						status_q <= STAT_OK;
						state_q <= (kind == KIND_STEP) ? S_F1 : S_FIN;
					end
				end
				S_F1: begin
					hi_q <= mem_rdata_q;
					state_q <= S_F2;
				end
				S_F2: begin
					op_q <= {hi_q, mem_rdata_q};
					state_q <= S_R1;
				end
				S_R1: begin
					vx_q <= v_rdata_q;
					state_q <= S_R2;
				end
				S_R2: begin
					vy_q <= v_rdata_q;
					state_q <= S_R3;
				end
				S_R3: begin
					v0_q <= v_rdata_q;
					state_q <= S_EX;
				end
				S_EX: begin
					pc_q <= pc_nxt;
					idx_q <= 4'd0;
					state_q <= S_FIN;
					case (op_q[15:12])
						4'h0: begin
							if (op_q == 16'h00E0) begin
								cnt_q <= 12'd0;
								state_q <= S_CLF;
							end else if (op_q == 16'h00EE) begin
								if (sl_q == '0) begin
									status_q <= STAT_UNDER;
								end else begin
									sl_q <= sl_m1;
									pc_q <= stk_rdata_q;
								end
							end
						end
						4'h1: pc_q <= op_nnn;
						4'h2: begin
							if (sl_q >= SLVL_W'(STACK_DEPTH)) begin
								status_q <= STAT_OVER;
							end else begin
								sl_q <= sl_q + SLVL_W'(1);
								pc_q <= op_nnn;
							end
						end
						4'h3: if (vx_q == op_nn) pc_q <= pc_skip;
						4'h4: if (vx_q != op_nn) pc_q <= pc_skip;
						4'h5: if (vx_q == vy_q) pc_q <= pc_skip;
						4'h8: begin
							if (alu_fop) begin
								flag_q <= alu_flag;
								state_q <= S_WF;
							end
						end
						4'h9: if (vx_q != vy_q) pc_q <= pc_skip;
						4'hA: i_q <= {4'd0, op_nnn};
						4'hB: pc_q <= {4'd0, v0_q} + op_nnn;
						4'hD: begin
							flag_q <= 1'b0;
							state_q <= (op_n == 4'd0) ? S_WF : S_DR1;
						end
						4'hF: begin
							case (op_nn)
								8'h15: dt_q <= vx_q;
								8'h18: st_q <= vx_q;
								8'h1E: i_q <= i_q + {8'd0, vx_q};
								8'h29: i_q <= {4'd0, FONT_BASE}
									+ {10'd0, vx_q[3:0], 2'd0} + {12'd0, vx_q[3:0]};
								8'h33: begin
									bcd_q <= bcd3(vx_q);
									state_q <= S_BCD;
								end
								8'h55: state_q <= S_ST1;
								8'h65: state_q <= S_LD1;
								default: ;
							endcase
						end
						default: ;
					endcase
				end
				S_WF: state_q <= S_FIN;
				S_CLF: begin
					cnt_q <= cnt_q + 12'd1;
					if (cnt_q == 12'd31)
						state_q <= S_FIN;
				end
				S_DR1: state_q <= S_DR2;
				S_DR2: begin
					if ((fb_rdata_q & mask) != 64'd0)
						flag_q <= 1'b1;
					idx_q <= idx_q + 4'd1;
					state_q <= (idx_q == op_n - 4'd1) ? S_WF : S_DR1;
				end
				S_ST1: state_q <= S_ST2;
				S_ST2: begin
					idx_q <= idx_q + 4'd1;
					state_q <= (idx_q == op_x) ? S_FIN : S_ST1;
				end
				S_LD1: state_q <= S_LD2;
				S_LD2: begin
					idx_q <= idx_q + 4'd1;
					state_q <= (idx_q == op_x) ? S_FIN : S_LD1;
				end
				S_BCD: begin
					idx_q <= idx_q + 4'd1;
					if (idx_q == 4'd2)
						state_q <= S_FIN;
				end
				S_FIN: begin
					done_q <= 1'b1;
					pc_out_q <= pc_q;
					instr_q <= (kind_q == KIND_STEP) ? op_q : 16'd0;
					row_q <= (kind_q == KIND_ROW) ? fb_rdata_q : 64'd0;
					if (kind_q == KIND_STEP) begin
						dt_q <= dt_dec;
						st_q <= st_dec;
						sound_q <= st_dec != 8'd0;
					end else begin
						sound_q <= st_q != 8'd0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign program_counter = pc_out_q;
	assign instruction = instr_q;
	assign row_pixels = row_q;
	assign sound_on = sound_q;
	assign status = status_q;

`ifndef NO_ASSERTIONS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held two cycles");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item left core idle");
	a_stack_range: assert property (@(posedge clk) disable iff (!arst_n)
		sl_q <= SLVL_W'(STACK_DEPTH)) else $error("stack level beyond depth");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status != 2'd3) else $error("invalid status code");
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_FIN) else $error("result outside finish");
`endif

endmodule

### bench/chip8_interpreter_core_top_tb.sv
`timescale 1ns / 1ps

module chip8_interpreter_core_top_tb;
	import c8i_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] load_address;
		logic [7:0]  load_byte;
		logic [7:0]  random_byte;
		logic [4:0]  row_select;
	} cmd_t;

	typedef struct packed {
		logic [11:0] program_counter;
		logic [15:0] instruction;
		logic [63:0] row_pixels;
		logic        sound_on;
		logic [1:0]  status;
	} res_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic [1:0]  kind;
	logic [11:0] load_address;
	logic [7:0]  load_byte;
	logic [7:0]  random_byte;
	logic [4:0]  row_select;
	logic        busy;
	logic        done;
	logic [11:0] program_counter;
	logic [15:0] instruction;
	logic [63:0] row_pixels;
	logic        sound_on;
	logic [1:0]  status;

	chip8_interpreter_core_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .kind(kind),
		.load_address(load_address), .load_byte(load_byte),
		.random_byte(random_byte), .row_select(row_select),
		.busy(busy), .done(done), .program_counter(program_counter),
		.instruction(instruction), .row_pixels(row_pixels),
		.sound_on(sound_on), .status(status)
	);

	// shadow machine state
	logic [7:0]  mem [4096];
	logic [7:0]  vreg [16];
	logic [15:0] ireg;
	logic [11:0] pc;
	logic [11:0] rstack [16];
	int          level;
	logic [7:0]  delay_t;
	logic [7:0]  sound_t;
	logic [63:0] frame [32];

	cmd_t cmd_queue[$];
	res_t expected_results[$];
	int   errors = 0;
	int   send_idle_pct;
	int   watchdog;
	bit   stim_done;
	bit   accepted_q;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	task automatic shadow_reset();
		for (int a = 0; a < 4096; a++) mem[a] = 8'h00;
		for (int a = 0; a < FONT_LEN; a++) mem[FONT_BASE + a] = FONT[a];
		for (int r = 0; r < 16; r++) begin
			vreg[r] = 8'h00;
			rstack[r] = 12'h000;
		end
		for (int r = 0; r < 32; r++) frame[r] = 64'd0;
		ireg = 16'h0000;
		pc = PC_RESET;
		level = 0;
		delay_t = 8'h00;
		sound_t = 8'h00;
	endtask

	function automatic logic [7:0] rd(input logic [31:0] a);
		return mem[a[11:0]];
	endfunction

	function automatic void run_alu(input int x, input int y, input logic [3:0] sub);
		logic [7:0] a, b, fl;
		logic [8:0] sum;
		a = vreg[x];
		b = vreg[y];
		case (sub)
			4'h0: vreg[x] = b;
			4'h1: vreg[x] = a | b;
			4'h2: vreg[x] = a & b;
			4'h3: vreg[x] = a ^ b;
			4'h4: begin
				sum = {1'b0, a} + {1'b0, b};
				vreg[x] = sum[7:0];
				vreg[15] = {7'd0, sum[8]};
			end
			4'h5: begin
				fl = (a >= b) ? 8'd1 : 8'd0;
				vreg[x] = a - b;
				vreg[15] = fl;
			end
			4'h6: begin
				vreg[x] = a >> 1;
				vreg[15] = {7'd0, a[0]};
			end
			4'h7: begin
				fl = (b >= a) ? 8'd1 : 8'd0;
				vreg[x] = b - a;
				vreg[15] = fl;
			end
			4'hE: begin
				vreg[x] = a << 1;
				vreg[15] = {7'd0, a[7]};
			end
			default: ;
		endcase
	endfunction

	function automatic void run_sprite(input int x, input int y, input int n);
		logic [7:0]  bits;
		logic [63:0] mask;
		int px, py, row, col;
		px = vreg[x] & 63;
		py = vreg[y];
		vreg[15] = 8'h00;
		for (int r = 0; r < n; r++) begin
			bits = rd(32'(ireg) + r);
			mask = 64'd0;
			row = (py + r) & 31;
			for (int c = 0; c < 8; c++) begin
				if (bits[7 - c]) begin
					col = (px + c) & 63;
					mask[63 - col] = 1'b1;
				end
			end
			if ((frame[row] & mask) != 64'd0) vreg[15] = 8'h01;
			frame[row] ^= mask;
		end
	endfunction

	function automatic void run_misc(input int x, input logic [7:0] nn);
		logic [7:0] v;
		v = vreg[x];
		case (nn)
			8'h07: vreg[x] = delay_t;
			8'h15: delay_t = v;
			8'h18: sound_t = v;
			8'h1E: ireg = ireg + 16'(v);
			8'h29: ireg = 16'(FONT_BASE) + 16'(v[3:0]) * 16'd5;
			8'h33: begin
				mem[ireg[11:0]] = v / 8'd100;
				mem[12'(ireg + 16'd1)] = (v / 8'd10) % 8'd10;
				mem[12'(ireg + 16'd2)] = v % 8'd10;
			end
			8'h55: for (int i = 0; i <= x; i++) mem[12'(ireg + 16'(i))] = vreg[i];
			8'h65: for (int i = 0; i <= x; i++) vreg[i] = mem[12'(ireg + 16'(i))];
			default: ;
		endcase
	endfunction

	function automatic logic [1:0] run_word(input logic [15:0] op);
		int x, y;
		logic [11:0] nxt;
		logic [1:0]  st;
		x = int'(op[11:8]);
		y = int'(op[7:4]);
		nxt = pc + 12'd2;
		st = STAT_OK;
		case (op[15:12])
			4'h0: begin
				if (op == 16'h00E0) begin
					for (int r = 0; r < 32; r++) frame[r] = 64'd0;
				end else if (op == 16'h00EE) begin
					if (level == 0) st = STAT_UNDER;
					else begin
						level--;
						nxt = rstack[level];
					end
				end
			end
			4'h1: nxt = op[11:0];
			4'h2: begin
				if (level >= STACK_DEPTH) st = STAT_OVER;
				else begin
					rstack[level] = nxt;
					level++;
					nxt = op[11:0];
				end
			end
			4'h3: if (vreg[x] == op[7:0]) nxt = nxt + 12'd2;
			4'h4: if (vreg[x] != op[7:0]) nxt = nxt + 12'd2;
			4'h5: if (vreg[x] == vreg[y]) nxt = nxt + 12'd2;
			4'h6: vreg[x] = op[7:0];
			4'h7: vreg[x] = vreg[x] + op[7:0];
			4'h8: run_alu(x, y, op[3:0]);
			4'h9: if (vreg[x] != vreg[y]) nxt = nxt + 12'd2;
			4'hA: ireg = {4'h0, op[11:0]};
			4'hB: nxt = 12'(vreg[0]) + op[11:0];
			4'hD: run_sprite(x, y, int'(op[3:0]));
			4'hE: ;
			4'hF: run_misc(x, op[7:0]);
			default: ;
		endcase
		pc = nxt;
		return st;
	endfunction

	function automatic res_t predict_result(input cmd_t c);
		res_t e;
		e = '0;
		if (c.kind == KIND_LOAD) begin
			mem[c.load_address] = c.load_byte;
		end else if (c.kind == KIND_STEP) begin
			e.instruction = {mem[pc], mem[pc + 12'd1]};
			if (e.instruction[15:12] == 4'hC) begin
				vreg[e.instruction[11:8]] = c.random_byte & e.instruction[7:0];
				pc = pc + 12'd2;
			end else begin
				e.status = run_word(e.instruction);
			end
			if (delay_t != 0) delay_t--;
			if (sound_t != 0) sound_t--;
		end else if (c.kind == KIND_ROW) begin
			e.row_pixels = frame[c.row_select];
		end
		e.program_counter = pc;
		e.sound_on = (sound_t != 0);
		return e;
	endfunction

	function automatic cmd_t mk(input logic [1:0] k, input logic [11:0] a,
			input logic [7:0] b, input logic [7:0] rnd, input logic [4:0] rs);
		cmd_t c;
		c.kind = k;
		c.load_address = a;
		c.load_byte = b;
		c.random_byte = rnd;
		c.row_select = rs;
		return c;
	endfunction

	// queue one load command that writes a byte at the given address
	task automatic push_load(input logic [11:0] a, input logic [7:0] b);
		cmd_queue.push_back(mk(KIND_LOAD, a, b, 8'($urandom), 5'($urandom)));
	endtask

	task automatic push_step(input logic [7:0] rnd);
		cmd_queue.push_back(mk(KIND_STEP, 12'($urandom), 8'($urandom), rnd, 5'($urandom)));
	endtask

	function automatic logic [15:0] rand_op();
		logic [15:0] op;
		int g;
		op = 16'($urandom);
		g = $urandom_range(0, 19);
		case (g)
			0: op = ($urandom_range(0, 1) != 0) ? 16'h00E0 : 16'h00EE;
			1: op[15:12] = 4'h2;
			2: op[15:12] = 4'h8;
			3: op = {4'h8, op[11:4], 4'($urandom_range(4, 7))};
			4: op = {4'h8, op[11:4], 4'hE};
			5: op[15:12] = 4'hD;
			6: op = {4'hD, op[11:4], 4'($urandom_range(0, 3))};
			7: op = {4'hF, op[11:8], 8'h33};
			8: op = {4'hF, op[11:8], 8'h55};
			9: op = {4'hF, op[11:8], 8'h65};
			10: op = {4'hF, op[11:8], 8'h29};
			11: op = {4'hF, op[11:8], 8'h1E};
			12: op = {4'hF, op[11:8], ($urandom_range(0, 1) != 0) ? 8'h15 : 8'h18};
			13: op = {4'hF, op[11:8], 8'h07};
			14: op[15:12] = 4'hC;
			15: op[15:12] = 4'h6;
			default: ;
		endcase
		return op;
	endfunction

	initial begin
		logic [15:0] op;
		logic [11:0] ld;
		int n;

		stim_done = 0;
		send_idle_pct = 8;
		shadow_reset();

		// directed: each instruction group but 1NNN, 2NNN and BNNN, stack underflow,
		// extreme row selects and the unused kind
		begin
			logic [15:0] prog [$];
			prog = '{16'h00EE, 16'h60FF, 16'h61FF, 16'h8014, 16'h8F15, 16'h8E0E,
				16'h8F06, 16'h8017, 16'h801B, 16'h3000, 16'h4000, 16'h5010,
				16'h9010, 16'h70FF, 16'hA050, 16'hD005, 16'hD00F, 16'hD000,
				16'hF029, 16'hF033, 16'hF255, 16'hF165, 16'hF318, 16'hF41E,
				16'hC0FF, 16'hE09E, 16'hF00A, 16'h0123, 16'h00E0};
			ld = PC_RESET;
			foreach (prog[k]) begin
				push_load(ld, prog[k][15:8]);
				push_load(ld + 12'd1, prog[k][7:0]);
				ld += 12'd2;
			end
			foreach (prog[k]) push_step((k == 24) ? 8'hFF : 8'h00);
		end
		cmd_queue.push_back(mk(KIND_ROW, 12'hFFF, 8'hFF, 8'hFF, 5'd0));
		cmd_queue.push_back(mk(KIND_ROW, 12'h000, 8'h00, 8'h00, 5'd31));
		cmd_queue.push_back(mk(2'd3, 12'hABC, 8'h5A, 8'hA5, 5'd7));

		// let the directed part drain, then hand over to the random phase
		n = 0;
		wait (arst_n);
		while (cmd_queue.size() != 0 || expected_results.size() != 0) @(posedge clk);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 84 : 0;
			for (int i = 0; i < 85; i++) begin
				n = $urandom_range(0, 99);
				if (n < 70) begin
					// well-formed: write the next word where the counter points
					op = rand_op();
					// stack calls target a plausible program area
					if (op[15:12] == 4'h2 && $urandom_range(0, 3) != 0)
						op[11:0] = 12'($urandom_range(12'h200, 12'hFFE));
					while (cmd_queue.size() != 0 || expected_results.size() != 0)
						@(posedge clk);
					push_load(pc, op[15:8]);
					push_load(pc + 12'd1, op[7:0]);
					push_step(8'($urandom));
				end else if (n < 85) begin
					cmd_queue.push_back(mk(KIND_ROW, 12'($urandom), 8'($urandom),
						8'($urandom), 5'($urandom)));
				end else if (n < 95) begin
					push_step(8'($urandom));
				end else begin
					cmd_queue.push_back(mk(2'($urandom), 12'($urandom),
						8'($urandom), 8'($urandom), 5'($urandom)));
				end
			end
		end
		stim_done = 1;
	end

	// reset release
	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// driver: hold the transaction until the rising edge that takes it
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			kind <= KIND_LOAD;
			load_address <= '0;
			load_byte <= '0;
			random_byte <= '0;
			row_select <= '0;
		end else if (!start || accepted_q) begin
			if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				cmd_t c;
				c = cmd_queue[0];
				start <= 1'b1;
				kind <= c.kind;
				load_address <= c.load_address;
				load_byte <= c.load_byte;
				random_byte <= c.random_byte;
				row_select <= c.row_select;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: transaction acceptance and result checks at the rising edge
	always @(posedge clk) begin
		res_t e;
		if (arst_n) begin
			accepted_q <= start && !busy;
			if (start && !busy)
				expected_results.push_back(predict_result(cmd_queue.pop_front()));
			if ((start && !busy) || done)
				watchdog <= 0;
			else
				watchdog <= watchdog + 1;
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result with nothing expected");
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (program_counter !== e.program_counter) begin
						$error("program_counter exp %h got %h", e.program_counter,
							program_counter);
						errors++;
					end
					if (instruction !== e.instruction) begin
						$error("instruction exp %h got %h", e.instruction, instruction);
						errors++;
					end
					if (row_pixels !== e.row_pixels) begin
						$error("row_pixels exp %h got %h", e.row_pixels, row_pixels);
						errors++;
					end
					if (sound_on !== e.sound_on) begin
						$error("sound_on exp %b got %b", e.sound_on, sound_on);
						errors++;
					end
					if (status !== e.status) begin
						$error("status exp %0d got %0d", e.status, status);
						errors++;
					end
				end
			end
		end else begin
			accepted_q <= 1'b0;
			watchdog <= 0;
		end
	end

	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (watchdog > WATCHDOG_LIMIT + 4096) begin
				$display("[chip8_interpreter_core_top] ERROR");
				$finish;
			end
			if (stim_done && cmd_queue.size() == 0 && expected_results.size() == 0
					&& !start) begin
				repeat (60) @(posedge clk);
				if (errors == 0 && expected_results.size() == 0)
					$display("[chip8_interpreter_core_top] OK");
				else
					$display("[chip8_interpreter_core_top] ERROR");
				$finish;
			end
		end
	end

endmodule
